[rtl/ipr_pkg.sv]
`default_nettype none

package ipr_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_SCALE = 100;

    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int COL_W     = $clog2(MAX_WIDTH + 1);
    localparam int SCALE_W   = $clog2(MAX_SCALE + 1);
    localparam int PIX_W     = 24;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int M_USER_W  = 3;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE = 1'b0,
        REG_WIDTH = 1'b1
    } t_cfg_reg;

    // Side information that travels with a result through the output pipeline.
    typedef struct packed {
        logic use_ram;
        logic is_pad;
        logic lend;
        logic gend;
        logic refused;
    } t_meta;

endpackage

`default_nettype wire

[rtl/integer_pixel_replication_scaler.sv]
// Integer pixel replication scaler.
// Slave stream: tuser carries the command (load a pixel or tick), tdata the
// 24-bit source pixel. Loads fill a line store of source_width pixels; once
// the row is full, each tick produces one output element. The row is sent
// scale times, each pixel repeated scale times, and every output line is
// followed by (width*scale) mod 4 zero padding elements.
// Master stream: tdata is the pixel (zero for padding), tlast marks the end
// of an output line, tuser flags padding, the end of the repeated line group
// and a refused load (a load that arrived while the row was still full).
// Configuration: a write enable, index and data; it is to be written only
// while idle by the user, as the block does not enforce this. One transaction
// is accepted per clock while the receiver does not stall. A result passes
// through the registered read of the line store and then the output register;
// a successful load or a tick while the row is not full gives no result.
// When the receiver stalls, the output register and the read stage hold and
// input is taken again as soon as the read stage can move on.
// Reset clears all counters and the output valid, sets scale and width to 1;
// the line store contents are not cleared.
`default_nettype none

module integer_pixel_replication_scaler (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Slave stream.
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [ipr_pkg::PIX_W-1:0]      i_s_tdata,   // [23:0] pixel
    input  wire logic                           i_s_tuser,   // [0] cmd
    // Master stream.
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic      [ipr_pkg::PIX_W-1:0]      o_m_tdata,   // [23:0] out_pixel
    output logic                                o_m_tlast,   // line_end
    output logic      [ipr_pkg::M_USER_W-1:0]   o_m_tuser,   // [0] is_pad,
                                                             // [1] group_end,
                                                             // [2] load_refused
    // Configuration.
    input  wire logic                           i_cfg_we,
    input  wire logic [ipr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ipr_pkg::CFG_W-1:0]      i_cfg_wdata
);

    logic [ipr_pkg::SCALE_W-1:0] r_scale;
    logic [ipr_pkg::COL_W-1:0]   r_width;

    logic [ipr_pkg::COL_W-1:0]   r_load_col,  n_load_col;
    logic                        r_row_ready, n_row_ready;
    logic [ipr_pkg::SCALE_W-1:0] r_line_rep,  n_line_rep;
    logic [ipr_pkg::COL_W-1:0]   r_emit_col,  n_emit_col;
    logic [ipr_pkg::SCALE_W-1:0] r_pix_rep,   n_pix_rep;
    logic [1:0]                  r_pad_cnt,   n_pad_cnt;
    logic                        r_in_pad,    n_in_pad;

    logic                        r_v1, n_v1;
    ipr_pkg::t_meta              r_m1, n_m1;
    logic                        r_v2;
    ipr_pkg::t_meta              r_m2;
    logic [ipr_pkg::PIX_W-1:0]   r_pix2;

    logic [ipr_pkg::SCALE_W-1:0] eff_s;
    logic [ipr_pkg::COL_W-1:0]   eff_w;
    logic [3:0]                  pad_prod;
    logic [1:0]                  pads;

    logic [ipr_pkg::COL_W-1:0]   load_inc;
    logic [ipr_pkg::COL_W-1:0]   emit_inc;
    logic [ipr_pkg::SCALE_W-1:0] pix_inc;
    logic [ipr_pkg::SCALE_W-1:0] line_inc;
    logic [1:0]                  pad_inc;

    logic                        s_acc;
    logic                        s1_adv;
    logic                        line_done;
    logic                        ram_we;
    logic                        ram_re;
    logic [ipr_pkg::PIX_W-1:0]   ram_rdata;

    // Effective register values: zero counts as one, large values saturate.
    always_comb begin
        if (r_scale == '0) begin
            eff_s = ipr_pkg::SCALE_W'(1);
        end else if (r_scale > ipr_pkg::SCALE_W'(ipr_pkg::MAX_SCALE)) begin
            eff_s = ipr_pkg::SCALE_W'(ipr_pkg::MAX_SCALE);
        end else begin
            eff_s = r_scale;
        end
        if (r_width == '0) begin
            eff_w = ipr_pkg::COL_W'(1);
        end else if (r_width > ipr_pkg::COL_W'(ipr_pkg::MAX_WIDTH)) begin
            eff_w = ipr_pkg::COL_W'(ipr_pkg::MAX_WIDTH);
        end else begin
            eff_w = r_width;
        end
    end

    // Only the two low bits of width and scale decide the padding count.
    assign pad_prod = {2'b00, eff_w[1:0]} * {2'b00, eff_s[1:0]};
    assign pads     = pad_prod[1:0];

    assign load_inc = r_load_col + ipr_pkg::COL_W'(1);
    assign emit_inc = r_emit_col + ipr_pkg::COL_W'(1);
    assign pix_inc  = r_pix_rep + ipr_pkg::SCALE_W'(1);
    assign line_inc = r_line_rep + ipr_pkg::SCALE_W'(1);
    assign pad_inc  = r_pad_cnt + 2'd1;

    assign s1_adv     = r_v1 && (!r_v2 || i_m_tready);
    assign o_s_tready = !r_v1 || s1_adv;
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_load_col  = r_load_col;
        n_row_ready = r_row_ready;
        n_line_rep  = r_line_rep;
        n_emit_col  = r_emit_col;
        n_pix_rep   = r_pix_rep;
        n_pad_cnt   = r_pad_cnt;
        n_in_pad    = r_in_pad;
        n_m1        = '0;
        line_done   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        n_v1        = s1_adv ? 1'b0 : r_v1;

        if (s_acc) begin
            n_v1 = 1'b0;
            if (i_s_tuser == ipr_pkg::CMD_LOAD) begin
                if (r_row_ready) begin
                    n_v1         = 1'b1;
                    n_m1.refused = 1'b1;
                end else begin
                    ram_we = 1'b1;
                    if (load_inc >= eff_w) begin
                        n_load_col  = '0;
                        n_row_ready = 1'b1;
                    end else begin
                        n_load_col = load_inc;
                    end
                end
            end else if (r_row_ready) begin
                n_v1 = 1'b1;
                if (!r_in_pad) begin
                    ram_re       = 1'b1;
                    n_m1.use_ram = 1'b1;
                    if (pix_inc >= eff_s) begin
                        n_pix_rep = '0;
                        if (emit_inc >= eff_w) begin
                            n_emit_col = '0;
                            if (pads != 2'd0) begin
                                n_in_pad  = 1'b1;
                                n_pad_cnt = 2'd0;
                            end else begin
                                line_done = 1'b1;
                            end
                        end else begin
                            n_emit_col = emit_inc;
                        end
                    end else begin
                        n_pix_rep = pix_inc;
                    end
                end else begin
                    n_m1.is_pad = 1'b1;
                    if (pad_inc >= pads) begin
                        n_pad_cnt = 2'd0;
                        n_in_pad  = 1'b0;
                        line_done = 1'b1;
                    end else begin
                        n_pad_cnt = pad_inc;
                    end
                end
                if (line_done) begin
                    if (line_inc >= eff_s) begin
                        n_line_rep  = '0;
                        n_m1.gend   = 1'b1;
                        n_row_ready = 1'b0;
                    end else begin
                        n_line_rep = line_inc;
                    end
                end
                n_m1.lend = line_done;
            end
        end
    end

    ipr_ram #(
        .WIDTH (ipr_pkg::PIX_W),
        .DEPTH (ipr_pkg::MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_load_col[ipr_pkg::ADDR_W-1:0]),
        .i_wdata (i_s_tdata),
        .i_re    (ram_re),
        .i_raddr (r_emit_col[ipr_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= ipr_pkg::SCALE_W'(1);
            r_width <= ipr_pkg::COL_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ipr_pkg::REG_SCALE: r_scale <= i_cfg_wdata[ipr_pkg::SCALE_W-1:0];
                ipr_pkg::REG_WIDTH: r_width <= i_cfg_wdata[ipr_pkg::COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_col  <= '0;
            r_row_ready <= 1'b0;
            r_line_rep  <= '0;
            r_emit_col  <= '0;
            r_pix_rep   <= '0;
            r_pad_cnt   <= 2'd0;
            r_in_pad    <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_load_col  <= n_load_col;
            r_row_ready <= n_row_ready;
            r_line_rep  <= n_line_rep;
            r_emit_col  <= n_emit_col;
            r_pix_rep   <= n_pix_rep;
            r_pad_cnt   <= n_pad_cnt;
            r_in_pad    <= n_in_pad;
            r_v1        <= n_v1;
            if (s1_adv) begin
                r_v2 <= 1'b1;
            end else if (i_m_tready) begin
                r_v2 <= 1'b0;
            end
        end
    end

    // Payload registers. The read stage only loads on an accepted transaction,
    // which keeps its metadata aligned with the held RAM read data.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_m1 <= n_m1;
        end
        if (s1_adv) begin
            r_m2   <= r_m1;
            r_pix2 <= r_m1.use_ram ? ram_rdata : '0;
        end
    end

    assign o_m_tvalid = r_v2;
    assign o_m_tdata  = r_pix2;
    assign o_m_tlast  = r_m2.lend;
    assign o_m_tuser  = {r_m2.refused, r_m2.gend, r_m2.is_pad};

`ifndef NO_ASSERTIONS
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("line store read and write in the same cycle");

    a_pad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_m2.is_pad || r_m2.refused)) |-> (o_m_tdata == '0))
        else $error("padding or refused element carries a nonzero pixel");

    a_group_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_m2.gend) |-> r_m2.lend)
        else $error("group end without line end");

    a_row_full_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_row_ready) |-> $past(ram_we))
        else $error("row marked full without a pixel load");

    a_refused_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_m2.refused) |-> !(r_m2.lend || r_m2.gend || r_m2.is_pad))
        else $error("refused load flagged as an emitted element");
`endif

endmodule

`default_nettype wire

[rtl/ipr_ram.sv]
`default_nettype none

module ipr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[tb/sv/integer_pixel_replication_scaler_test.sv]
`timescale 1ns / 1ps

module integer_pixel_replication_scaler_test;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_PCT      = 36;
    localparam int ITEM_COUNT    = 950;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic [ipr_pkg::PIX_W-1:0] pixel;
        logic                      is_pad;
        logic                      line_end;
        logic                      group_end;
        logic                      refused;
    } t_scaled_elem;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_s_tvalid  = 1'b0;
    logic                          o_s_tready;
    logic [ipr_pkg::PIX_W-1:0]     i_s_tdata   = '0;
    logic                          i_s_tuser   = ipr_pkg::CMD_LOAD;
    logic                          o_m_tvalid;
    logic                          i_m_tready  = 1'b0;
    logic [ipr_pkg::PIX_W-1:0]     o_m_tdata;
    logic                          o_m_tlast;
    logic [ipr_pkg::M_USER_W-1:0]  o_m_tuser;
    logic                          i_cfg_we    = 1'b0;
    logic [ipr_pkg::CFG_IDX_W-1:0] i_cfg_idx   = ipr_pkg::REG_SCALE;
    logic [ipr_pkg::CFG_W-1:0]     i_cfg_wdata = '0;

    // Shadow copy of the scaler state, advanced once per accepted transaction.
    logic [ipr_pkg::SCALE_W-1:0] scale_reg  = 1;
    logic [ipr_pkg::CFG_W-1:0]   width_reg  = 1;
    logic [ipr_pkg::PIX_W-1:0]   row_pixels [ipr_pkg::MAX_WIDTH];
    int                          load_col   = 0;
    int                          emit_col   = 0;
    int                          pixel_reps = 0;
    int                          line_reps  = 0;
    int                          pads_sent  = 0;
    bit                          row_full   = 1'b0;
    bit                          in_padding = 1'b0;

    t_scaled_elem pending_elems[$];
    int           error_count = 0;
    int           sent_items  = 0;
    int           cycle_count = 0;
    bit           steady      = 1'b0;

    integer_pixel_replication_scaler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("integer_pixel_replication_scaler: mismatch");
            $finish;
        end
    end

    function automatic logic [ipr_pkg::PIX_W-1:0] rand_pixel();
        logic [31:0] word;
        word = $urandom();
        return word[ipr_pkg::PIX_W-1:0];
    endfunction

    function automatic string elem_text(input t_scaled_elem e);
        return $sformatf("pixel %h pad %b lend %b gend %b refused %b",
                         e.pixel, e.is_pad, e.line_end, e.group_end, e.refused);
    endfunction

    function automatic int active_scale();
        if (scale_reg == 0) return 1;
        if (scale_reg > ipr_pkg::MAX_SCALE) return ipr_pkg::MAX_SCALE;
        return int'(scale_reg);
    endfunction

    function automatic int active_width();
        if (width_reg == 0) return 1;
        if (width_reg > ipr_pkg::MAX_WIDTH) return ipr_pkg::MAX_WIDTH;
        return int'(width_reg);
    endfunction

    task automatic replicate_step(input ipr_pkg::t_cmd cmd,
                                  input logic [ipr_pkg::PIX_W-1:0] pix);
        int           s;
        int           w;
        int           pads;
        t_scaled_elem e;
        s    = active_scale();
        w    = active_width();
        pads = (w * s) % 4;
        e    = '0;
        if (cmd == ipr_pkg::CMD_LOAD) begin
            if (row_full) begin
                e.refused = 1'b1;
                pending_elems.push_back(e);
            end else begin
                row_pixels[load_col % ipr_pkg::MAX_WIDTH] = pix;
                load_col++;
                if (load_col >= w) begin
                    load_col = 0;
                    row_full = 1'b1;
                end
            end
        end else if (row_full) begin
            if (!in_padding) begin
                e.pixel = row_pixels[emit_col % ipr_pkg::MAX_WIDTH];
                pixel_reps++;
                if (pixel_reps >= s) begin
                    pixel_reps = 0;
                    emit_col++;
                    if (emit_col >= w) begin
                        emit_col = 0;
                        if (pads != 0) begin
                            in_padding = 1'b1;
                            pads_sent  = 0;
                        end else begin
                            e.line_end = 1'b1;
                        end
                    end
                end
            end else begin
                e.is_pad = 1'b1;
                pads_sent++;
                if (pads_sent >= pads) begin
                    pads_sent  = 0;
                    in_padding = 1'b0;
                    e.line_end = 1'b1;
                end
            end
            if (e.line_end) begin
                line_reps++;
                if (line_reps >= s) begin
                    line_reps   = 0;
                    e.group_end = 1'b1;
                    row_full    = 1'b0;
                end
            end
            pending_elems.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin : check_output
        t_scaled_elem got;
        t_scaled_elem want;
        got = {o_m_tdata, o_m_tuser[0], o_m_tlast, o_m_tuser[1], o_m_tuser[2]};
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_elems.size() == 0) begin
                $display("%0t: expected no transaction, got %s", $time, elem_text(got));
                error_count++;
            end else begin
                want = pending_elems.pop_front();
                if (got !== want) begin
                    $display("%0t: expected %s, got %s", $time, elem_text(want),
                             elem_text(got));
                    error_count++;
                end
            end
        end
    end

    task automatic stream_in(input ipr_pkg::t_cmd cmd,
                             input logic [ipr_pkg::PIX_W-1:0] pix);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pix;
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sent_items++;
        replicate_step(cmd, pix);
    endtask

    // Loads give no result, so a short wait covers any load still in flight.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_elems.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input ipr_pkg::t_cfg_reg idx,
                             input logic [ipr_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == ipr_pkg::REG_SCALE) scale_reg = data[ipr_pkg::SCALE_W-1:0];
        else width_reg = data;
    endtask

    task automatic set_geometry(input logic [ipr_pkg::CFG_W-1:0] scale_word,
                                input logic [ipr_pkg::CFG_W-1:0] width_word);
        settle();
        write_reg(ipr_pkg::REG_SCALE, scale_word);
        write_reg(ipr_pkg::REG_WIDTH, width_word);
    endtask

    // Fills whatever is left of the row, then ticks until the group is done.
    task automatic play_row(input int stray_pct, input int refuse_pct);
        while (!row_full) begin
            if ($urandom_range(99) < stray_pct) stream_in(ipr_pkg::CMD_TICK, rand_pixel());
            else stream_in(ipr_pkg::CMD_LOAD, rand_pixel());
        end
        while (row_full) begin
            if ($urandom_range(99) < refuse_pct) stream_in(ipr_pkg::CMD_LOAD, rand_pixel());
            else stream_in(ipr_pkg::CMD_TICK, rand_pixel());
        end
    endtask

    task automatic test_default_geometry();
        stream_in(ipr_pkg::CMD_TICK, 24'h5A5A5A);
        stream_in(ipr_pkg::CMD_LOAD, 24'hFFFFFF);
        stream_in(ipr_pkg::CMD_LOAD, 24'h000000);
        stream_in(ipr_pkg::CMD_TICK, 24'h000000);
        stream_in(ipr_pkg::CMD_TICK, 24'hFFFFFF);
        stream_in(ipr_pkg::CMD_LOAD, 24'h000000);
        stream_in(ipr_pkg::CMD_TICK, 24'hA5A5A5);
        stream_in(ipr_pkg::CMD_TICK, 24'h5A5A5A);
    endtask

    task automatic test_pad_lengths();
        set_geometry(11'd1, 11'd3);
        stream_in(ipr_pkg::CMD_LOAD, 24'h0000FF);
        stream_in(ipr_pkg::CMD_LOAD, 24'h00FF00);
        stream_in(ipr_pkg::CMD_LOAD, 24'hFF0000);
        stream_in(ipr_pkg::CMD_LOAD, 24'h123456);
        play_row(0, 0);
        // Four elements per line: no padding, two lines per group.
        set_geometry(11'd2, 11'd2);
        play_row(0, 0);
    endtask

    task automatic test_mid_row_change();
        set_geometry(11'd2, 11'd6);
        repeat (3) stream_in(ipr_pkg::CMD_LOAD, rand_pixel());
        // The row already holds more pixels than the new width.
        settle();
        write_reg(ipr_pkg::REG_WIDTH, 11'd2);
        stream_in(ipr_pkg::CMD_LOAD, rand_pixel());
        repeat (3) stream_in(ipr_pkg::CMD_TICK, rand_pixel());
        settle();
        write_reg(ipr_pkg::REG_SCALE, 11'd1);
        repeat (2) stream_in(ipr_pkg::CMD_TICK, rand_pixel());
        settle();
        write_reg(ipr_pkg::REG_WIDTH, 11'd1);
        play_row(0, 10);

        set_geometry(11'd3, 11'd5);
        repeat (2) stream_in(ipr_pkg::CMD_LOAD, rand_pixel());
        settle();
        write_reg(ipr_pkg::REG_WIDTH, 11'd7);
        play_row(10, 10);

        // Widening during output also reaches entries that earlier rows wrote.
        set_geometry(11'd2, 11'd3);
        repeat (3) stream_in(ipr_pkg::CMD_LOAD, rand_pixel());
        repeat (2) stream_in(ipr_pkg::CMD_TICK, rand_pixel());
        settle();
        write_reg(ipr_pkg::REG_WIDTH, 11'd6);
        play_row(0, 10);

        set_geometry(11'd3, 11'd1);
        stream_in(ipr_pkg::CMD_LOAD, rand_pixel());
        repeat (7) stream_in(ipr_pkg::CMD_TICK, rand_pixel());
        settle();
        write_reg(ipr_pkg::REG_SCALE, 11'd1);
        play_row(0, 10);
    endtask

    task automatic test_register_limits();
        set_geometry(11'd0, 11'd0);
        play_row(10, 10);
        // A single pixel line ends after the saturated scale count of elements.
        set_geometry(11'h07F, 11'd1);
        steady = 1'b1;
        stream_in(ipr_pkg::CMD_LOAD, rand_pixel());
        repeat (ipr_pkg::MAX_SCALE + 1) stream_in(ipr_pkg::CMD_TICK, rand_pixel());
        steady = 1'b0;
        settle();
        write_reg(ipr_pkg::REG_SCALE, 11'd1);
        play_row(0, 10);
        // An oversized width must not close the row early.
        set_geometry(11'd1, 11'h7FF);
        repeat (40) stream_in(ipr_pkg::CMD_LOAD, rand_pixel());
        settle();
        write_reg(ipr_pkg::REG_WIDTH, 11'd4);
        play_row(2, 10);
    endtask

    task automatic test_random_rows();
        int                        s;
        int                        w;
        int                        rows;
        logic [ipr_pkg::CFG_W-1:0] scale_word;
        while (sent_items < ITEM_COUNT) begin
            case ($urandom_range(9))
                7, 8: begin
                    s = $urandom_range(1, 2);
                    w = $urandom_range(9, 32);
                end
                9: begin
                    s = $urandom_range(5, 8);
                    w = $urandom_range(1, 2);
                end
                default: begin
                    s = $urandom_range(1, 4);
                    w = $urandom_range(1, 8);
                end
            endcase
            // Bits above the scale field must be ignored.
            scale_word = $urandom_range(2047);
            scale_word[ipr_pkg::SCALE_W-1:0] = s[ipr_pkg::SCALE_W-1:0];
            set_geometry(scale_word, w[ipr_pkg::CFG_W-1:0]);
            rows = $urandom_range(1, 3);
            while (rows > 0 && sent_items < ITEM_COUNT) begin
                play_row(8, 8);
                rows--;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_geometry();
        test_pad_lengths();
        test_mid_row_change();
        test_register_limits();
        test_random_rows();
        settle();
        if (error_count == 0) begin
            $display("integer_pixel_replication_scaler: match");
        end else begin
            $display("integer_pixel_replication_scaler: mismatch");
        end
        $finish;
    end

endmodule
